/* hw/rtl/brlt_pkg.sv */
package brlt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W = 64 * 5 + 1;

	localparam logic [1:0] OP_ACQUIRE   = 2'd0;
	localparam logic [1:0] OP_RELEASE   = 2'd1;
	localparam logic [1:0] OP_TEST      = 2'd2;
	localparam logic [1:0] OP_REL_OWNER = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_CONFLICT = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] dataset;
		logic [63:0] inode;
		logic [63:0] owner;
		logic [1:0]  lock_kind;
		logic [63:0] start_offset;
		logic [63:0] length;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        would_grant;
		logic [63:0] conflict_owner;
		logic [6:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [63:0] dataset;
		logic [63:0] inode;
		logic [63:0] owner;
		logic        exclusive;
		logic [63:0] start;
		logic [63:0] fin;
	} entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic             latch_req;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             eval;      // read data of the previous cycle is valid
		logic             wr_new;    // append the request at used count
		logic             finish;    // commit keep count (compaction ops)
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [2:0]       pre_status; // checks on the request alone
		logic [CNT_W-1:0] used;
		logic             conflict;
	} sts_t;

endpackage

/* hw/rtl/byte_range_lock_table_top.sv */
// Advisory byte-range lock table.
// A request enters on the req channel (req_valid/req_ready) and carries an
// operation: acquire, release of an exact range, test, or release of every
// lock of one owner. Exactly one response leaves on the rsp channel
// (rsp_valid/rsp_ready) for each request, in order.
// Every operation that passes its checks scans the stored entries through
// one memory read port, one entry per cycle; a request rejected by its
// checks skips the scan. Release operations compact the table during the
// same scan through the write port.
// One request is worked at a time; a new request is taken once the last
// response has been taken or is being taken, so a stalled receiver simply
// holds the response register and delays the next request.
// Reset empties the table at once: only the entry count is cleared, since
// entries at or above it are never read.
module byte_range_lock_table_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  brlt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output brlt_pkg::rsp_t  rsp
);
	import brlt_pkg::*;

	cmd_t cmd;
	sts_t sts;
	rsp_t info;
	logic snap;

	brlt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req_valid), .in_ready(req_ready),
		.in_op(req.op), .out_valid(rsp_valid), .out_ready(rsp_ready),
		.sts(sts), .cmd(cmd), .snap(snap)
	);

	brlt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts), .rsp_info(info)
	);

	// The response register is loaded at the same clock edge at which valid rises.
	always_ff @(posedge clk) begin
		if (snap) rsp <= info;
	end

	// The table never holds more entries than its depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		sts.used <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above depth");

	// An append only happens when the table has room.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_new |-> sts.used < CNT_W'(TABLE_DEPTH))
		else $error("append into full table");

	// No request is taken while a response waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("request taken under stalled response");
endmodule

/* hw/rtl/brlt_ram.sv */
module brlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/brlt_datapath.sv */
module brlt_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  brlt_pkg::req_t req,
	input  brlt_pkg::cmd_t cmd,
	output brlt_pkg::sts_t sts,
	output brlt_pkg::rsp_t rsp_info
);
	import brlt_pkg::*;

	req_t             req_q;
	logic [63:0]      end_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] kept_q;
	logic             found_q;
	logic             added_q;
	logic [63:0]      cown_q;
	logic [2:0]       pre_q;
	entry_t           rd_ent;
	logic [ENT_W-1:0] rd_raw;
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;
	logic             drop, hit;
	logic [64:0]      sum;

	assign sum = {1'b0, req.start_offset} + {1'b0, req.length};

	brlt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(rd_raw)
	);
	assign rd_ent = entry_t'(rd_raw);

	always_comb begin
		hit = (rd_ent.dataset == req_q.dataset) && (rd_ent.inode == req_q.inode)
			&& (req_q.start_offset < rd_ent.fin) && (rd_ent.start < end_q)
			&& (rd_ent.owner != req_q.owner)
			&& (req_q.lock_kind[0] || rd_ent.exclusive);
		if (req_q.op == OP_REL_OWNER) begin
			drop = rd_ent.owner == req_q.owner;
		end else begin
			drop = (rd_ent.dataset == req_q.dataset) && (rd_ent.inode == req_q.inode)
				&& (rd_ent.owner == req_q.owner) && (rd_ent.start == req_q.start_offset)
				&& (rd_ent.fin == end_q);
		end
		we    = 1'b0;
		waddr = kept_q[IDX_W-1:0];
		wdata = rd_ent;
		if (cmd.wr_new) begin
			we    = 1'b1;
			waddr = used_q[IDX_W-1:0];
			wdata = '{dataset: req_q.dataset, inode: req_q.inode, owner: req_q.owner,
				exclusive: req_q.lock_kind[0], start: req_q.start_offset, fin: end_q};
		end else if (cmd.eval && (req_q.op == OP_RELEASE || req_q.op == OP_REL_OWNER)
				&& !drop) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			kept_q  <= '0;
			found_q <= 1'b0;
			added_q <= 1'b0;
		end else begin
			if (cmd.latch_req) begin
				req_q   <= req;
				end_q   <= (req.length == 64'd0) ? '1 : sum[63:0];
				kept_q  <= '0;
				found_q <= 1'b0;
				added_q <= 1'b0;
				cown_q  <= '0;
				if (req.op == OP_REL_OWNER)
					pre_q <= (req.owner == 64'd0) ? ST_INVALID : ST_OK;
				else if (req.dataset == 64'd0 || req.inode == 64'd0 || req.owner == 64'd0)
					pre_q <= ST_INVALID;
				else if (req.op != OP_RELEASE && req.lock_kind[1])
					pre_q <= ST_INVALID;
				else if (req.length != 64'd0 && sum[64])
					pre_q <= ST_OVERFLOW;
				else
					pre_q <= ST_OK;
			end
			if (cmd.eval) begin
				if (!drop) kept_q <= kept_q + 1'b1;
				if (hit && !found_q) begin
					found_q <= 1'b1;
					cown_q  <= rd_ent.owner;
				end
			end
			if (cmd.wr_new) begin
				used_q  <= used_q + 1'b1;
				added_q <= 1'b1;
			end
			if (cmd.finish) used_q <= kept_q;
		end
	end

	assign sts.pre_status = pre_q;
	assign sts.used       = used_q;
	assign sts.conflict   = found_q;

	// An acquire that passed its checks and found no conflict is refused only
	// when the append did not take place for want of room.
	always_comb begin
		rsp_info.status         = pre_q;
		rsp_info.would_grant    = 1'b0;
		rsp_info.conflict_owner = '0;
		rsp_info.entry_count    = 7'(used_q);
		if (pre_q == ST_OK && req_q.op == OP_TEST) begin
			rsp_info.would_grant    = !found_q;
			rsp_info.conflict_owner = cown_q;
		end else if (pre_q == ST_OK && req_q.op == OP_ACQUIRE) begin
			if (found_q) rsp_info.status = ST_CONFLICT;
			else if (!added_q) rsp_info.status = ST_FULL;
		end
	end
endmodule

/* hw/rtl/brlt_ctrl.sv */
module brlt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     in_op,
	output logic           out_valid,
	input  logic           out_ready,
	input  brlt_pkg::sts_t sts,
	output brlt_pkg::cmd_t cmd,
	output logic           snap
);
	import brlt_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_DONE, S_APPEND, S_RESP} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] idx_q;
	logic [1:0]       op_q;
	logic             last;

	assign in_ready = (state_q == S_IDLE) && !(out_valid && !out_ready);
	assign last     = (idx_q + 1'b1) >= sts.used;

	always_comb begin
		cmd = '0;
		snap = 1'b0;
		cmd.latch_req = in_valid && in_ready;
		cmd.rd_addr   = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_CHECK: cmd.rd_en = (sts.pre_status == ST_OK) && (sts.used != '0);
			S_SCAN: begin
				cmd.eval  = 1'b1;
				cmd.rd_en = !last;
				cmd.rd_addr = IDX_W'(idx_q + 1'b1);
			end
			S_DONE: cmd.finish = (op_q == OP_RELEASE || op_q == OP_REL_OWNER);
			S_APPEND: cmd.wr_new = !sts.conflict && (sts.used != CNT_W'(TABLE_DEPTH));
			S_RESP: snap = 1'b1;
			default: ;
		endcase
		if (state_q == S_CHECK && sts.pre_status == ST_OK && sts.used == '0
				&& op_q != OP_ACQUIRE) cmd.finish = (op_q != OP_TEST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			op_q      <= OP_ACQUIRE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.latch_req) begin
					op_q    <= in_op;
					idx_q   <= '0;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (sts.pre_status != ST_OK) state_q <= S_RESP;
					else if (sts.used == '0)
						state_q <= (op_q == OP_ACQUIRE) ? S_APPEND : S_RESP;
					else state_q <= S_SCAN;
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (last) state_q <= S_DONE;
				end
				S_DONE: state_q <= (op_q == OP_ACQUIRE) ? S_APPEND : S_RESP;
				S_APPEND: state_q <= S_RESP;
				S_RESP: begin
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* bench/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brlt_pkg::*;

	localparam int GAP_MAX = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	byte_range_lock_table_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// The testbench keeps its own copy of the lock table. Only entries below
	// lock_count are ever looked at, so the rest may hold anything.
	entry_t lock_tbl[TABLE_DEPTH];
	int lock_count;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors;
	int reqs_sent;
	int rsps_seen;
	int granted_acquires;
	int conflicts_seen;
	int full_seen;
	int req_gap;
	int rsp_gap;
	int idle_cycles;
	bit stim_done;

	// Small pools of ids and offsets make conflicts and exact releases common.
	logic [63:0] ds_pool[4];
	logic [63:0] ino_pool[4];
	logic [63:0] own_pool[6];

	// Computes the response that the block owes for one request and updates
	// the local table in the same way the block should.
	function automatic rsp_t lock_table_apply(req_t r);
		rsp_t res;
		logic [63:0] fin;
		logic excl;
		bit found;
		int kept;
		res = '0;
		res.status = ST_OK;
		fin = '1;
		found = 0;
		excl = (r.lock_kind == 2'd1);
		if (r.op == OP_REL_OWNER) begin
			if (r.owner == 64'd0) begin
				res.status = ST_INVALID;
			end else begin
				kept = 0;
				for (int i = 0; i < lock_count; i++) begin
					if (lock_tbl[i].owner != r.owner) begin
						lock_tbl[kept] = lock_tbl[i];
						kept++;
					end
				end
				lock_count = kept;
			end
		end else if (r.dataset == 64'd0 || r.inode == 64'd0 || r.owner == 64'd0) begin
			res.status = ST_INVALID;
		end else if (r.op != OP_RELEASE && r.lock_kind > 2'd1) begin
			res.status = ST_INVALID;
		end else if (r.length != 64'd0 && r.start_offset > ~r.length) begin
			res.status = ST_OVERFLOW;
		end else begin
			if (r.length != 64'd0)
				fin = r.start_offset + r.length;
			if (r.op == OP_RELEASE) begin
				kept = 0;
				for (int i = 0; i < lock_count; i++) begin
					if (!(lock_tbl[i].dataset == r.dataset && lock_tbl[i].inode == r.inode
						&& lock_tbl[i].owner == r.owner
						&& lock_tbl[i].start == r.start_offset
						&& lock_tbl[i].fin == fin)) begin
						lock_tbl[kept] = lock_tbl[i];
						kept++;
					end
				end
				lock_count = kept;
			end else begin
				for (int i = 0; i < lock_count && !found; i++) begin
					if (lock_tbl[i].dataset == r.dataset && lock_tbl[i].inode == r.inode
						&& r.start_offset < lock_tbl[i].fin
						&& lock_tbl[i].start < fin
						&& lock_tbl[i].owner != r.owner
						&& (excl || lock_tbl[i].exclusive)) begin
						found = 1;
						if (r.op == OP_TEST)
							res.conflict_owner = lock_tbl[i].owner;
					end
				end
				if (r.op == OP_TEST) begin
					res.would_grant = !found;
				end else if (found) begin
					res.status = ST_CONFLICT;
				end else if (lock_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					lock_tbl[lock_count].dataset = r.dataset;
					lock_tbl[lock_count].inode = r.inode;
					lock_tbl[lock_count].owner = r.owner;
					lock_tbl[lock_count].exclusive = excl;
					lock_tbl[lock_count].start = r.start_offset;
					lock_tbl[lock_count].fin = fin;
					lock_count++;
				end
			end
		end
		res.entry_count = 7'(lock_count);
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic [63:0] ds, logic [63:0] ino,
		logic [63:0] own, logic [1:0] kind, logic [63:0] st, logic [63:0] len);
		req_t r;
		r.op = op;
		r.dataset = ds;
		r.inode = ino;
		r.owner = own;
		r.lock_kind = kind;
		r.start_offset = st;
		r.length = len;
		return r;
	endfunction

	// Mostly well-formed requests drawn from the pools, with some fully random
	// noise so that every bit of every field gets exercised.
	function automatic req_t random_req();
		req_t r;
		int pick;
		logic [415:0] raw;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom()};
			r = req_t'(raw[$bits(req_t)-1:0]);
			return r;
		end
		r.dataset = ds_pool[$urandom_range(0, 3)];
		r.inode = ino_pool[$urandom_range(0, 3)];
		r.owner = own_pool[$urandom_range(0, 5)];
		r.lock_kind = $urandom_range(0, 9) == 0 ? 2'($urandom_range(2, 3))
			: 2'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: r.start_offset = rand64();
			1: r.start_offset = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255));
			default: r.start_offset = 64'($urandom_range(0, 200));
		endcase
		case ($urandom_range(0, 9))
			0: r.length = 64'd0;
			1: r.length = rand64();
			default: r.length = 64'($urandom_range(1, 60));
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.op = OP_ACQUIRE;
		else if (pick < 65)
			r.op = OP_TEST;
		else if (pick < 93)
			r.op = OP_RELEASE;
		else
			r.op = OP_REL_OWNER;
		// Releases mostly aim at a lock that is really held.
		if (r.op == OP_RELEASE && lock_count > 0 && $urandom_range(0, 3) != 0) begin
			pick = $urandom_range(0, lock_count - 1);
			r.dataset = lock_tbl[pick].dataset;
			r.inode = lock_tbl[pick].inode;
			r.owner = lock_tbl[pick].owner;
			r.start_offset = lock_tbl[pick].start;
			r.length = (lock_tbl[pick].fin == '1) ? 64'd0
				: lock_tbl[pick].fin - lock_tbl[pick].start;
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stimulus. The predictor runs here as requests are queued, since the
	// block serves them strictly in order.
	initial begin
		req_t r;
		arst_n = 1'b0;
		errors = 0;
		lock_count = 0;
		stim_done = 0;
		for (int i = 0; i < 4; i++) begin
			ds_pool[i] = (i == 3) ? '1 : 64'(i + 1);
			ino_pool[i] = (i == 3) ? rand64() | 64'd1 : 64'(i + 10);
		end
		for (int i = 0; i < 6; i++)
			own_pool[i] = (i == 5) ? '1 : 64'(i + 100);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: rejections, ranges at the limits, sharing and
		// conflicts, tests, releases with and without a match, owner release.
		pending_reqs.push_back(make_req(OP_ACQUIRE, 0, 1, 1, 0, 0, 1));
		pending_reqs.push_back(make_req(OP_TEST, 1, 0, 1, 0, 0, 1));
		pending_reqs.push_back(make_req(OP_RELEASE, 1, 1, 0, 0, 0, 1));
		pending_reqs.push_back(make_req(OP_REL_OWNER, 5, 5, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_ACQUIRE, 1, 1, 1, 2, 0, 1));
		pending_reqs.push_back(make_req(OP_TEST, 1, 1, 1, 3, 0, 1));
		pending_reqs.push_back(make_req(OP_ACQUIRE, 1, 1, 1, 0, '1, 1));
		pending_reqs.push_back(make_req(OP_ACQUIRE, 1, 1, 1, 0, '1, 0));
		pending_reqs.push_back(make_req(OP_ACQUIRE, 1, 1, 2, 0, 10, 10));
		pending_reqs.push_back(make_req(OP_ACQUIRE, 1, 1, 3, 1, 19, 5));
		pending_reqs.push_back(make_req(OP_ACQUIRE, 1, 1, 3, 1, 20, 5));
		pending_reqs.push_back(make_req(OP_TEST, 1, 1, 4, 1, 0, 0));
		pending_reqs.push_back(make_req(OP_TEST, 1, 1, 4, 0, 30, 0));
		pending_reqs.push_back(make_req(OP_TEST, 2, 1, 4, 1, 0, 0));
		pending_reqs.push_back(make_req(OP_ACQUIRE, '1, '1, '1, 1, 0, '1));
		pending_reqs.push_back(make_req(OP_RELEASE, 1, 1, 3, 3, 20, 6));
		pending_reqs.push_back(make_req(OP_RELEASE, 1, 1, 3, 2, 20, 5));
		pending_reqs.push_back(make_req(OP_REL_OWNER, 0, 0, 2, 3, 0, 0));
		pending_reqs.push_back(make_req(OP_REL_OWNER, 0, 0, 1, 0, 0, 0));
		// Fill the table to the brim, hit the full case, then release the filling owner's locks.
		for (int i = 0; i < TABLE_DEPTH + 1; i++)
			pending_reqs.push_back(make_req(OP_ACQUIRE, 7, 7, 7, 0, 64'(i * 4), 2));
		pending_reqs.push_back(make_req(OP_TEST, 7, 7, 8, 1, 0, 0));
		pending_reqs.push_back(make_req(OP_REL_OWNER, 0, 0, 7, 0, 0, 0));
		foreach (pending_reqs[i])
			expected_rsps.push_back(lock_table_apply(pending_reqs[i]));

		// Random part. The local table is used to aim releases, so the
		// prediction must be made as each request is generated.
		for (int n = 0; n < 1300; n++) begin
			wait (pending_reqs.size() < 4);
			r = random_req();
			pending_reqs.push_back(r);
			expected_rsps.push_back(lock_table_apply(r));
			if ($urandom_range(0, 199) == 0)
				for (int k = 0; k < 6; k++) begin
					r = make_req(OP_REL_OWNER, 0, 0, own_pool[k], 0, 0, 0);
					pending_reqs.push_back(r);
					expected_rsps.push_back(lock_table_apply(r));
				end
			@(posedge clk);
		end
		stim_done = 1;
	end

	// Request driver: one random idle gap is drawn per request, and quite often there is none.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			req_gap <= 0;
			reqs_sent <= 0;
		end else if (!req_valid || req_ready) begin
			if (req_valid)
				reqs_sent <= reqs_sent + 1;
			if (req_gap > 0) begin
				req_valid <= 1'b0;
				req_gap <= req_gap - 1;
			end else if (pending_reqs.size() > 0) begin
				req_valid <= 1'b1;
				req <= pending_reqs.pop_front();
				req_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, GAP_MAX);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response monitor and ready pattern.
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_gap <= 0;
			rsps_seen <= 0;
			granted_acquires <= 0;
			conflicts_seen <= 0;
			full_seen <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsps_seen <= rsps_seen + 1;
				if (expected_rsps.size() == 0) begin
					$display("%0t: response with nothing expected: %p", $realtime, rsp);
					errors++;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp.status == ST_CONFLICT)
						conflicts_seen <= conflicts_seen + 1;
					if (rsp.status == ST_FULL)
						full_seen <= full_seen + 1;
					if (rsp.status == ST_OK && rsp.entry_count != 0)
						granted_acquires <= granted_acquires + 1;
					if (rsp.status !== exp_rsp.status) begin
						$display("%0t: status expected %0d actual %0d", $realtime,
							exp_rsp.status, rsp.status);
						errors++;
					end
					if (rsp.would_grant !== exp_rsp.would_grant) begin
						$display("%0t: would_grant expected %0d actual %0d", $realtime,
							exp_rsp.would_grant, rsp.would_grant);
						errors++;
					end
					if (rsp.conflict_owner !== exp_rsp.conflict_owner) begin
						$display("%0t: conflict_owner expected %h actual %h", $realtime,
							exp_rsp.conflict_owner, rsp.conflict_owner);
						errors++;
					end
					if (rsp.entry_count !== exp_rsp.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d", $realtime,
							exp_rsp.entry_count, rsp.entry_count);
						errors++;
					end
				end
			end
			// A fresh stall length is drawn for each response.
			if (rsp_gap > 0) begin
				rsp_ready <= 1'b0;
				rsp_gap <= rsp_gap - 1;
			end else if (rsp_valid && rsp_ready) begin
				rsp_ready <= 1'b0;
				rsp_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, GAP_MAX);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: the run fails once the idle count with no request or response taken reaches
	// WATCHDOG_LIMIT, a wide margin over a full-table scan plus the longest stall on both sides.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout after %0d idle cycles", idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// End of run: all requests out, every response back, then a short drain
	// to catch any stray response.
	initial begin
		wait (stim_done && pending_reqs.size() == 0 && !req_valid);
		wait (expected_rsps.size() == 0);
		repeat (100) @(posedge clk);
		$display("Sent %0d requests and checked %0d responses.", reqs_sent, rsps_seen);
		$display("Responses with entries held: %0d, conflicts: %0d, table full: %0d.",
			granted_acquires, conflicts_seen, full_seen);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
